@@ rtl/bcra_pkg.sv @@
// shared constants, codes and control types for the contiguous run allocator
package bcra_pkg;

    localparam int MAP_BITS      = 65536;
    localparam int WORD_BITS     = 64;
    localparam int WORD_LSB      = $clog2(WORD_BITS);
    localparam int MAP_WORDS     = MAP_BITS / WORD_BITS;
    localparam int WADDR_W       = $clog2(MAP_WORDS);
    localparam int CL_W          = 16;
    localparam int RUN_W         = CL_W + 1;
    localparam int FIRST_CLUSTER = 2;

    typedef enum logic [1:0] {
        CMD_MARK_USED = 2'd0,
        CMD_MARK_FREE = 2'd1,
        CMD_FIND      = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        STAT_MARKED = 2'd0,
        STAT_FOUND  = 2'd1,
        STAT_NONE   = 2'd2,
        STAT_RANGE  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MARK_RD,
        S_MARK_WR,
        S_SEARCH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic    clear;
        logic    load;
        logic    mark_rd;
        logic    mark_wr;
        logic    srch_start;
        logic    search;
        logic    set_res;
        status_t res_code;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic       clear_last;
        logic [1:0] command;
        logic       in_range;
        logic       len_zero;
        logic       srch_done;
        logic       out_free;
    } dp_stat_t;

endpackage

@@ rtl/bcra_ram.sv @@
// generic simple dual port ram with registered read
module bcra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bcra_ctrl.sv @@
// controller state machine for the contiguous run allocator
module bcra_ctrl import bcra_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_code = STAT_RANGE;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.command)
                    CMD_MARK_USED, CMD_MARK_FREE: begin
                        if (stat.in_range) begin
                            state_next = S_MARK_RD;
                        end else begin
                            cmd.set_res  = 1'b1;
                            cmd.res_code = STAT_RANGE;
                            state_next   = S_FINISH;
                        end
                    end
                    CMD_FIND: begin
                        if (stat.len_zero) begin
                            cmd.set_res  = 1'b1;
                            cmd.res_code = STAT_NONE;
                            state_next   = S_FINISH;
                        end else begin
                            cmd.srch_start = 1'b1;
                            state_next     = S_SEARCH;
                        end
                    end
                    default: begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = STAT_RANGE;
                        state_next   = S_FINISH;
                    end
                endcase
            end
            S_MARK_RD: begin
                cmd.mark_rd = 1'b1;
                state_next  = S_MARK_WR;
            end
            S_MARK_WR: begin
                cmd.mark_wr  = 1'b1;
                cmd.set_res  = 1'b1;
                cmd.res_code = STAT_MARKED;
                state_next   = S_FINISH;
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                if (stat.srch_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/bcra_dp.sv @@
// datapath: bitmap memory, word scan pipeline, mark logic and result register
module bcra_dp import bcra_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [CL_W-1:0] cfg_wr_data,
    input  logic [1:0]      s_command,
    input  logic [CL_W-1:0] s_cluster,
    input  logic [CL_W-1:0] s_run_length,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_status,
    output logic [CL_W-1:0] m_first_cluster,
    input  dp_cmd_t         cmd,
    output dp_stat_t        stat
);

    localparam int LVLS = WORD_LSB;

    // configuration: highest valid cluster
    logic [CL_W-1:0] hi_reg;
    logic [CL_W-1:0] hi_next;
    logic [CL_W:0]   cfg_p1;

    // captured item
    logic [1:0]      command_reg;
    logic [CL_W-1:0] cluster_reg;
    logic [CL_W-1:0] len_reg;

    // memory
    logic                 ram_we;
    logic [WADDR_W-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WADDR_W-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] mark_word;

    logic [WADDR_W-1:0]  clr_addr_reg;
    logic [WADDR_W-1:0]  cl_word;
    logic [WORD_LSB-1:0] cl_bit;
    logic [WADDR_W-1:0]  hi_word;
    logic [WORD_LSB-1:0] hi_bit;

    // scan pipeline
    logic               issue_fire;
    logic               issue_done_reg;
    logic [WADDR_W-1:0] srch_addr_reg;
    logic               v1_reg;
    logic [WADDR_W-1:0] w1_reg;

    logic [WORD_BITS-1:0] used_eff;
    logic [WORD_BITS-1:0] pv [LVLS+1];
    logic [WORD_LSB-1:0]  pi [LVLS+1][WORD_BITS];

    logic                 va_reg;
    logic [WADDR_W-1:0]   wa_reg;
    logic [WORD_BITS-1:0] lu_v_reg;
    logic [WORD_LSB-1:0]  lu_i_reg [WORD_BITS];

    logic [RUN_W-1:0]     run_reg;
    logic [RUN_W-1:0]     run_i [WORD_BITS];
    logic [RUN_W-1:0]     run_last;
    logic [WORD_BITS-1:0] hit;
    logic                 any_hit;
    logic [WORD_LSB-1:0]  hit_idx;
    logic                 srch_done;

    // result
    status_t         res_status_reg;
    logic [CL_W-1:0] res_end_reg;
    logic [CL_W-1:0] res_first;
    logic            m_valid_reg;
    status_t         m_status_reg;
    logic [CL_W-1:0] m_first_reg;

    assign cfg_p1  = (CL_W+1)'(cfg_wr_data) + (CL_W+1)'(1);
    assign hi_next = (cfg_p1 > (CL_W+1)'(MAP_BITS - 1)) ? CL_W'(MAP_BITS - 1)
                                                          : cfg_p1[CL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg <= CL_W'(1);
        end else if (cfg_wr_en) begin
            hi_reg <= hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            command_reg <= s_command;
            cluster_reg <= s_cluster;
            len_reg     <= s_run_length;
        end
    end

    assign cl_word = cluster_reg[WORD_LSB +: WADDR_W];
    assign cl_bit  = cluster_reg[WORD_LSB-1:0];
    assign hi_word = hi_reg[WORD_LSB +: WADDR_W];
    assign hi_bit  = hi_reg[WORD_LSB-1:0];

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear) begin
            clr_addr_reg <= clr_addr_reg + WADDR_W'(1);
        end
    end

    always_comb begin
        mark_word         = rd_data;
        mark_word[cl_bit] = (command_reg == CMD_MARK_USED);
    end

    assign issue_fire = cmd.search && !issue_done_reg;

    assign ram_we    = cmd.clear || cmd.mark_wr;
    assign ram_waddr = cmd.clear ? clr_addr_reg : cl_word;
    assign ram_wdata = cmd.clear ? '0 : mark_word;
    assign ram_re    = cmd.mark_rd || issue_fire;
    assign ram_raddr = cmd.mark_rd ? cl_word : srch_addr_reg;

    bcra_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(rd_data)
    );

    // word address issue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_done_reg <= 1'b1;
            srch_addr_reg  <= '0;
        end else if (cmd.srch_start) begin
            issue_done_reg <= 1'b0;
            srch_addr_reg  <= '0;
        end else if (issue_fire) begin
            if (srch_addr_reg == hi_word) begin
                issue_done_reg <= 1'b1;
            end else begin
                srch_addr_reg <= srch_addr_reg + WADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            va_reg <= 1'b0;
        end else begin
            v1_reg <= issue_fire;
            va_reg <= v1_reg && !cmd.srch_start;
        end
    end

    always_ff @(posedge aclk) begin
        w1_reg <= srch_addr_reg;
    end

    // stage a: mask clusters outside the valid range, then latest used bit per position
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            used_eff[i] = rd_data[i]
                        || ((w1_reg == '0) && (i < FIRST_CLUSTER))
                        || ((w1_reg == hi_word) && (WORD_LSB'(i) > hi_bit));
        end
        pv[0] = used_eff;
        for (int i = 0; i < WORD_BITS; i++) begin
            pi[0][i] = WORD_LSB'(i);
        end
        for (int k = 0; k < LVLS; k++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (pv[k][i] || (i < (1 << k))) begin
                    pv[k+1][i] = pv[k][i];
                    pi[k+1][i] = pi[k][i];
                end else begin
                    pv[k+1][i] = pv[k][i - (1 << k)];
                    pi[k+1][i] = pi[k][i - (1 << k)];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        wa_reg   <= w1_reg;
        lu_v_reg <= pv[LVLS];
        for (int i = 0; i < WORD_BITS; i++) begin
            lu_i_reg[i] <= pi[LVLS][i];
        end
    end

    // stage b: free run length ending at each bit, lowest match
    always_comb begin
        for (int i = 0; i < WORD_BITS; i++) begin
            run_i[i] = lu_v_reg[i] ? (RUN_W'(i) - RUN_W'(lu_i_reg[i]))
                                   : (run_reg + RUN_W'(i + 1));
            hit[i]   = (run_i[i] >= RUN_W'(len_reg));
        end
        hit_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx = WORD_LSB'(i);
            end
        end
    end

    assign any_hit   = |hit;
    assign run_last  = run_i[WORD_BITS-1];
    assign srch_done = va_reg && cmd.search && (any_hit || (wa_reg == hi_word));

    always_ff @(posedge aclk) begin
        if (cmd.srch_start) begin
            run_reg <= '0;
        end else if (va_reg && cmd.search) begin
            run_reg <= run_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_code;
        end else if (srch_done) begin
            res_status_reg <= any_hit ? STAT_FOUND : STAT_NONE;
            res_end_reg    <= {wa_reg, hit_idx};
        end
    end

    assign res_first = (res_status_reg == STAT_FOUND)
                     ? (res_end_reg - len_reg + CL_W'(1)) : '0;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_first_reg  <= res_first;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_first_cluster = m_first_reg;

    assign stat.clear_last = (clr_addr_reg == WADDR_W'(MAP_WORDS - 1));
    assign stat.command    = command_reg;
    assign stat.in_range   = (cluster_reg >= CL_W'(FIRST_CLUSTER)) && (cluster_reg <= hi_reg);
    assign stat.len_zero   = (len_reg == '0);
    assign stat.srch_done  = srch_done;
    assign stat.out_free   = !m_valid_reg || m_ready;

endmodule

@@ rtl/bitmap_contiguous_run_allocator.sv @@
// top level of the bitmap first-fit contiguous run allocator
// after reset the map is cleared one 64-bit word per cycle over all 1024 words, no transfer taken
// one item at a time; a mark passes through decode, map read, map write and finish to result valid
// a search reads one 64-bit map word per cycle from cluster 0 up to the stopping word
// other commands answer through decode and finish; reset is synchronous, active low, cluster count 0
module bitmap_contiguous_run_allocator import bcra_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [CL_W-1:0] cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_command,
    input  logic [CL_W-1:0] s_cluster,
    input  logic [CL_W-1:0] s_run_length,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_status,
    output logic [CL_W-1:0] m_first_cluster
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bcra_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    bcra_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_command      (s_command),
        .s_cluster      (s_cluster),
        .s_run_length   (s_run_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_first_cluster(m_first_cluster),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule

@@ rtl/bcra_checker.sv @@
// port level checks for the contiguous run allocator, bound to the top level
module bcra_checker import bcra_pkg::*; (
    input logic            aclk,
    input logic            aresetn,
    input logic            cfg_wr_en,
    input logic [CL_W-1:0] cfg_wr_data,
    input logic            s_valid,
    input logic            s_ready,
    input logic [1:0]      s_command,
    input logic [CL_W-1:0] s_cluster,
    input logic [CL_W-1:0] s_run_length,
    input logic            m_valid,
    input logic            m_ready,
    input logic [1:0]      m_status,
    input logic [CL_W-1:0] m_first_cluster
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_first_cluster))
        else $error("result changed while stalled");

    // only a found run carries a cluster
    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_FOUND) |-> (m_first_cluster == '0))
        else $error("first cluster nonzero without a found run");

    // a found run never starts below the first data cluster
    a_first_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_FOUND) |-> (m_first_cluster >= CL_W'(FIRST_CLUSTER)))
        else $error("found run starts below first data cluster");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken while busy");

    // reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bitmap_contiguous_run_allocator bcra_checker u_bcra_checker (.*);
